// ===== hdl/lrss_pkg.sv =====
// ----------------------------------------------------------------------------
// lrss_pkg
// Shared types, constants and target pose table of the recovery sequencer.
// ----------------------------------------------------------------------------
package lrss_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int JOINTS      = 3;
    localparam int NUM_LEGS    = 4;
    localparam int RAMP_BITS   = 16;
    localparam int HEIGHT_BITS = 12;
    localparam int LEG_BITS    = 48;
    localparam int DIV_STEPS   = 17;
    // floor(x / 10) = (x * THR_MULT) >> THR_SHIFT for x below 2^22
    localparam int THR_MULT    = 838861;
    localparam int THR_SHIFT   = 23;

    typedef logic signed [ANGLE_BITS-1:0] angle_t;

    // motion phase codes
    localparam logic [1:0] PH_STAND = 2'd0;
    localparam logic [1:0] PH_FOLD  = 2'd1;
    localparam logic [1:0] PH_ROLL  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_STANDUP_RAMP  = 3'd0;
    localparam logic [2:0] CFG_FOLD_RAMP     = 3'd1;
    localparam logic [2:0] CFG_FOLD_SETTLE   = 3'd2;
    localparam logic [2:0] CFG_ROLL_RAMP     = 3'd3;
    localparam logic [2:0] CFG_ROLL_SETTLE   = 3'd4;
    localparam logic [2:0] CFG_STAND_MIN     = 3'd5;
    localparam logic [2:0] CFG_STAND_MAX     = 3'd6;
    localparam logic [2:0] CFG_LOW_HEIGHT    = 3'd7;

    // Q4.12 targets
    localparam angle_t T_STAND_1 = 16'sd2949;
    localparam angle_t T_STAND_2 = -16'sd5898;
    localparam angle_t T_FOLD_1  = 16'sd5734;
    localparam angle_t T_FOLD_2  = -16'sd11059;
    localparam angle_t T_ROLL_2  = -16'sd11346;
    localparam angle_t T_R08     = 16'sd3277;
    localparam angle_t T_R13     = 16'sd5325;
    localparam angle_t T_R24     = 16'sd9830;
    localparam angle_t T_R33     = 16'sd13517;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       do_enter;
        logic       do_abort;
        logic       mul_start;
        logic       div_init;
        logic       div_step;
        logic       acc;
        logic       push;
        logic [1:0] leg;
        logic [1:0] jnt;
    } lrss_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic abort;
        logic out_free;
    } lrss_status_t;

    function automatic angle_t target_angle(logic [1:0] ph, logic left_side,
                                            logic odd, logic [1:0] j);
        angle_t a;
        a = '0;
        if (ph == PH_STAND)
        begin
            case (j)
                2'd1:    a = T_STAND_1;
                2'd2:    a = T_STAND_2;
                default: a = '0;
            endcase
        end
        else if (ph == PH_ROLL)
        begin
            case (j)
                2'd0:
                begin
                    if (left_side)
                        a = odd ? T_R13 : -T_R08;
                    else
                        a = odd ? T_R08 : -T_R13;
                end
                2'd1:
                begin
                    if (left_side == odd)
                        a = T_R33;
                    else
                        a = T_R24;
                end
                2'd2:    a = T_ROLL_2;
                default: a = '0;
            endcase
        end
        else
        begin
            case (j)
                2'd1:    a = T_FOLD_1;
                2'd2:    a = T_FOLD_2;
                default: a = '0;
            endcase
        end
        return a;
    endfunction

endpackage

// ===== hdl/lrss_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrss_ctrl
// Sequencing state machine: decide, then per joint multiply, divide, store.
// ----------------------------------------------------------------------------
module lrss_ctrl
    import lrss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  lrss_status_t status,
    output lrss_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_DINIT  = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_ACC    = 7'b0100000,
        S_PUSH   = 7'b1000000
    } state_t;

    localparam int STEP_BITS = $clog2(DIV_STEPS);

    state_t               state_reg, state_next;
    logic [1:0]           leg_reg, leg_next;
    logic [1:0]           jnt_reg, jnt_next;
    logic [STEP_BITS-1:0] step_reg, step_next;

    assign s_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        leg_next   = leg_reg;
        jnt_next   = jnt_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.leg    = leg_reg;
        cmd.jnt    = jnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!status.is_tick)
                begin
                    cmd.do_enter = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (status.abort)
                begin
                    cmd.do_abort = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    leg_next   = '0;
                    jnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(DIV_STEPS - 1))
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (jnt_reg == 2'(JOINTS - 1))
                begin
                    jnt_next = '0;
                    leg_next = leg_reg + 1'b1;
                    if (leg_reg == 2'(NUM_LEGS - 1))
                        state_next = S_PUSH;
                    else
                        state_next = S_MUL;
                end
                else
                begin
                    jnt_next   = jnt_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            leg_reg   <= '0;
            jnt_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            leg_reg   <= leg_next;
            jnt_reg   <= jnt_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== hdl/lrss_datapath.sv =====
// ----------------------------------------------------------------------------
// lrss_datapath
// Config registers, sequencer state, start pose, shared multiplier and
// restoring divider, result buffer and output register.
// ----------------------------------------------------------------------------
module lrss_datapath
    import lrss_pkg::*;
#(
    parameter int TICK_BITS = 17
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tuser,
    input  logic [207:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,
    output logic [1:0]   m_tuser,
    input  lrss_cmd_t    cmd,
    output lrss_status_t status
);

    localparam int TW = (TICK_BITS > RAMP_BITS + 1) ? TICK_BITS : RAMP_BITS + 1;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    // configuration
    logic [RAMP_BITS-1:0]   standup_ramp_reg, fold_ramp_reg, fold_settle_reg;
    logic [RAMP_BITS-1:0]   roll_ramp_reg, roll_settle_reg;
    logic [HEIGHT_BITS-1:0] stand_min_reg, stand_max_reg, low_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            standup_ramp_reg <= 16'd500;
            fold_ramp_reg    <= 16'd400;
            fold_settle_reg  <= 16'd100;
            roll_ramp_reg    <= 16'd100;
            roll_settle_reg  <= 16'd150;
            stand_min_reg    <= 12'd200;
            stand_max_reg    <= 12'd450;
            low_height_reg   <= 12'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STANDUP_RAMP: standup_ramp_reg <= cfg_wdata;
                CFG_FOLD_RAMP:    fold_ramp_reg    <= cfg_wdata;
                CFG_FOLD_SETTLE:  fold_settle_reg  <= cfg_wdata;
                CFG_ROLL_RAMP:    roll_ramp_reg    <= cfg_wdata;
                CFG_ROLL_SETTLE:  roll_settle_reg  <= cfg_wdata;
                CFG_STAND_MIN:    stand_min_reg    <= cfg_wdata[HEIGHT_BITS-1:0];
                CFG_STAND_MAX:    stand_max_reg    <= cfg_wdata[HEIGHT_BITS-1:0];
                CFG_LOW_HEIGHT:   low_height_reg   <= cfg_wdata[HEIGHT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // captured input item
    logic                   cmd_reg;
    logic                   upside_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [LEG_BITS-1:0]    meas_reg [NUM_LEGS];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg    <= s_tuser;
            upside_reg <= s_tdata[0];
            height_reg <= s_tdata[HEIGHT_BITS:1];
            for (int l = 0; l < NUM_LEGS; l++)
                meas_reg[l] <= s_tdata[1 + HEIGHT_BITS + l*LEG_BITS +: LEG_BITS];
        end
    end

    // sequencer state
    logic [1:0]           phase_reg, phase_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic                 left_side_reg, left_side_next;
    angle_t               start_reg [NUM_LEGS][JOINTS];

    logic [TW-1:0] tick_ext;
    assign tick_ext = TW'(tick_reg);

    // effective ramp of the current phase (zero counts as one)
    logic [RAMP_BITS-1:0] ramp_raw, ramp;
    always_comb
    begin
        case (phase_reg)
            PH_STAND: ramp_raw = standup_ramp_reg;
            PH_ROLL:  ramp_raw = roll_ramp_reg;
            default:  ramp_raw = fold_ramp_reg;
        endcase
        ramp = (ramp_raw == '0) ? RAMP_BITS'(1) : ramp_raw;
    end

    // stand-up abort threshold floor(0.7 * R), by reciprocal multiply
    logic [RAMP_BITS-1:0]   sr_eff;
    logic [RAMP_BITS+2:0]   sr_x7;
    logic [RAMP_BITS+22:0]  thr_prod;
    logic [RAMP_BITS-1:0]   thr_reg;
    assign sr_eff   = (standup_ramp_reg == '0) ? RAMP_BITS'(1) : standup_ramp_reg;
    assign sr_x7    = {sr_eff, 3'b000} - (RAMP_BITS+3)'(sr_eff);
    assign thr_prod = (RAMP_BITS+23)'(sr_x7) * (RAMP_BITS+23)'(THR_MULT);

    always_ff @(posedge clk)
    begin
        thr_reg <= thr_prod[THR_SHIFT +: RAMP_BITS];
    end

    assign status.is_tick  = cmd_reg;
    assign status.abort    = (phase_reg == PH_STAND) && (tick_ext > TW'(thr_reg)) &&
                             (upside_reg || (height_reg < low_height_reg));

    // multiply stage: (target - start) * t
    angle_t              s_sel, f_sel;
    logic signed [16:0]  diff;
    logic signed [16:0]  tmul;
    logic signed [33:0]  prod_next, prod_reg;
    angle_t              s_reg, f_reg;
    logic                beyond_reg;

    assign s_sel     = start_reg[cmd.leg][cmd.jnt];
    assign f_sel     = target_angle(phase_reg, left_side_reg, cmd.leg[0], cmd.jnt);
    assign diff      = 17'(f_sel) - 17'(s_sel);
    assign tmul      = {1'b0, tick_ext[RAMP_BITS-1:0]};
    assign prod_next = 34'(diff) * 34'(tmul);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            prod_reg   <= prod_next;
            s_reg      <= s_sel;
            f_reg      <= f_sel;
            beyond_reg <= tick_ext > TW'(ramp);
        end
    end

    // restoring divider: (2|n| + R) / (2R), 17 quotient bits
    logic               neg;
    logic [32:0]        mag;
    logic [33:0]        dvd_full;
    logic [16:0]        rem_reg, dvd_reg, quo_reg;
    logic [16:0]        divisor;
    logic [17:0]        trial;
    logic               take;

    assign neg      = prod_reg[33];
    assign mag      = neg ? 33'(-prod_reg) : 33'(prod_reg);
    assign dvd_full = {mag, 1'b0} + 34'(ramp);
    assign divisor  = {ramp, 1'b0};
    assign trial    = {rem_reg, dvd_reg[16]};
    assign take     = trial >= 18'(divisor);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= dvd_full[33:17];
            dvd_reg <= dvd_full[16:0];
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= take ? 17'(trial - 18'(divisor)) : trial[16:0];
            dvd_reg <= {dvd_reg[15:0], 1'b0};
            quo_reg <= {quo_reg[15:0], take};
        end
    end

    // setpoint of one joint
    logic signed [17:0] qs;
    logic signed [17:0] v;
    angle_t             res_reg [NUM_LEGS][JOINTS];

    assign qs = neg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign v  = beyond_reg ? 18'(f_reg) : 18'(s_reg) + qs;

    always_ff @(posedge clk)
    begin
        if (cmd.acc)
            res_reg[cmd.leg][cmd.jnt] <= v[ANGLE_BITS-1:0];
    end

    // phase end tests
    logic [RAMP_BITS:0] fold_end, roll_end;
    assign fold_end = 17'(ramp) + 17'(fold_settle_reg);
    assign roll_end = 17'(ramp) + 17'(roll_settle_reg);

    logic [TICK_BITS-1:0] tick_adv;
    assign tick_adv = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;

    // start pose update sources
    logic latch_meas, latch_tgt;
    logic [1:0] tgt_phase;

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        left_side_next = left_side_reg;
        latch_meas     = 1'b0;
        latch_tgt      = 1'b0;
        tgt_phase      = phase_reg;
        if (cmd.do_enter)
        begin
            latch_meas = 1'b1;
            tick_next  = '0;
            if (!upside_reg && (stand_min_reg < height_reg) &&
                (height_reg < stand_max_reg))
                phase_next = PH_STAND;
            else
                phase_next = PH_FOLD;
        end
        else if (cmd.do_abort)
        begin
            latch_meas = 1'b1;
            tick_next  = '0;
            phase_next = PH_FOLD;
        end
        else if (cmd.push)
        begin
            case (phase_reg)
                PH_STAND: tick_next = tick_adv;
                PH_ROLL:
                begin
                    if (tick_ext > TW'(roll_end))
                    begin
                        latch_tgt      = 1'b1;
                        phase_next     = PH_FOLD;
                        left_side_next = !left_side_reg;
                        tick_next      = '0;
                    end
                    else
                        tick_next = tick_adv;
                end
                default:
                begin
                    if (tick_ext >= TW'(fold_end))
                    begin
                        latch_tgt  = 1'b1;
                        phase_next = upside_reg ? PH_ROLL : PH_STAND;
                        tick_next  = '0;
                    end
                    else
                        tick_next = tick_adv;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FOLD;
            tick_reg      <= '0;
            left_side_reg <= 1'b1;
        end
        else
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            left_side_reg <= left_side_next;
        end
    end

    // start pose
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NUM_LEGS; l++)
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                if (latch_meas)
                    start_reg[l][j] <= meas_reg[l][j*ANGLE_BITS +: ANGLE_BITS];
                else if (latch_tgt)
                    start_reg[l][j] <= target_angle(tgt_phase, left_side_reg,
                                                    1'(l), 2'(j));
            end
        end
    end

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [LEG_BITS-1:0]  out_leg_reg [NUM_LEGS];
    logic [1:0]           out_phase_reg;

    assign status.out_free = !out_valid_reg || m_tready;
    assign out_valid_next  = cmd.push ? 1'b1 : (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_phase_reg <= phase_reg;
            for (int l = 0; l < NUM_LEGS; l++)
                out_leg_reg[l] <= {res_reg[l][2], res_reg[l][1], res_reg[l][0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_phase_reg;
    always_comb
    begin
        for (int l = 0; l < NUM_LEGS; l++)
            m_tdata[l*LEG_BITS +: LEG_BITS] = out_leg_reg[l];
    end

endmodule

// ===== hdl/legged_recovery_stand_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// legged_recovery_stand_sequencer_core
// Recovery stand sequencer for a four-legged robot, joint setpoint generator.
// ----------------------------------------------------------------------------
// An enter item (tuser 0) latches the pose, picks the first phase and gives
// no result, as does a stand-up abort. A tick item (tuser 1) runs the 12 joint
// setpoints one after another through one shared multiplier and one
// restoring divider (1 multiply, 1 set-up, 17 divide steps and 1 store per
// joint), then the result is loaded into the output register, where it may
// wait while the next item is taken in.
module legged_recovery_stand_sequencer_core
    import lrss_pkg::*;
#(
    parameter int TICK_BITS = 17
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // upside_down, height, measured_leg0..3, zero pad
    input  logic [207:0] s_tdata,
    // cmd
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // setpoint_leg0..3
    output logic [191:0] m_tdata,
    // motion_phase
    output logic [1:0]   m_tuser
);

    lrss_cmd_t    cmd;
    lrss_status_t status;

    lrss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lrss_datapath #(
        .TICK_BITS (TICK_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== hdl/lrss_checker.sv =====
// ----------------------------------------------------------------------------
// lrss_checker
// Port-level checks of the recovery sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lrss_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // only the three phase codes are ever reported
    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == 2'd0 || m_tuser == 2'd1 || m_tuser == 2'd2))
        else $error("motion_phase out of range");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an accepted item is worked on before the next is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while busy");

    // an enter item never raises a new result on the next cycle
    a_enter_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("enter item gave a result");

endmodule

bind legged_recovery_stand_sequencer_core lrss_checker u_lrss_checker (.*);

// ===== dv/legged_recovery_stand_sequencer_core_test.sv =====
// ----------------------------------------------------------------------------
// legged_recovery_stand_sequencer_core_test
// Self-checking bench: directed and random enter/tick items with random gaps
// and output stalls, setpoints checked against a behavioural predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module legged_recovery_stand_sequencer_core_test;
    import lrss_pkg::*;

    localparam int TICKW     = 17;
    localparam int TICK_TOP  = (1 << TICKW) - 1;
    localparam int CYCLE_CAP = 3000000;

    typedef struct packed {
        logic         cmd;
        logic         upside;
        logic [11:0]  height;
        logic [191:0] legs;
    } item_t;

    typedef struct packed {
        logic [191:0] legs;
        logic [1:0]   ph;
    } setpoint_t;

    // directed rows, expected result typed in where obvious
    typedef struct packed {
        item_t     it;
        logic      known;
        setpoint_t res;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;

    legged_recovery_stand_sequencer_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor state
    logic [15:0] r_stand, r_fold, s_fold, r_roll, s_roll;
    logic [11:0] h_min, h_max, h_low;
    logic [1:0]  m_phase;
    int          m_tick;
    angle_t      m_start [12];
    logic        m_left;

    setpoint_t   pending_setpoints[$];
    int          errors;
    int          cycles;

    function automatic longint rdiv(longint n, longint d);
        if (n >= 0)
            return (2 * n + d) / (2 * d);
        return -((-2 * n + d) / (2 * d));
    endfunction

    function automatic angle_t pose_of(logic [1:0] ph, int leg, int j);
        angle_t a;
        a = '0;
        if (ph == PH_STAND)
            a = (j == 1) ? T_STAND_1 : (j == 2) ? T_STAND_2 : angle_t'(0);
        else if (ph == PH_ROLL)
        begin
            if (j == 2)
                a = T_ROLL_2;
            else if (j == 1)
                a = (m_left == leg[0]) ? T_R33 : T_R24;
            else if (m_left)
                a = leg[0] ? T_R13 : -T_R08;
            else
                a = leg[0] ? T_R08 : -T_R13;
        end
        else
            a = (j == 1) ? T_FOLD_1 : (j == 2) ? T_FOLD_2 : angle_t'(0);
        return a;
    endfunction

    function automatic setpoint_t interpolate(logic [1:0] ph, int ramp);
        setpoint_t r;
        longint    s, f, v;
        r.ph = ph;
        for (int leg = 0; leg < 4; leg++)
            for (int j = 0; j < 3; j++)
            begin
                s = m_start[leg * 3 + j];
                f = pose_of(ph, leg, j);
                v = f;
                if (m_tick <= ramp)
                    v = s + rdiv((f - s) * m_tick, ramp);
                r.legs[(leg * 3 + j) * 16 +: 16] = v[15:0];
            end
        return r;
    endfunction

    function automatic void latch_pose(logic [191:0] legs);
        for (int k = 0; k < 12; k++)
            m_start[k] = legs[k * 16 +: 16];
    endfunction

    function automatic void latch_phase(logic [1:0] ph);
        for (int k = 0; k < 12; k++)
            m_start[k] = pose_of(ph, k / 3, k % 3);
    endfunction

    function automatic void bump();
        if (m_tick < TICK_TOP)
            m_tick++;
    endfunction

    // returns 1 and the setpoints when the item produces a result
    function automatic bit predict_setpoints(item_t it, output setpoint_t r);
        int ramp;
        r = '0;
        if (!it.cmd)
        begin
            latch_pose(it.legs);
            m_tick  = 0;
            m_phase = (!it.upside && h_min < it.height && it.height < h_max)
                      ? PH_STAND : PH_FOLD;
            return 0;
        end
        if (m_phase == PH_STAND)
        begin
            ramp = (r_stand == 0) ? 1 : r_stand;
            if (m_tick > (7 * ramp) / 10 && (it.upside || it.height < h_low))
            begin
                latch_pose(it.legs);
                m_phase = PH_FOLD;
                m_tick  = 0;
                return 0;
            end
            r = interpolate(PH_STAND, ramp);
            bump();
            return 1;
        end
        if (m_phase == PH_ROLL)
        begin
            ramp = (r_roll == 0) ? 1 : r_roll;
            r = interpolate(PH_ROLL, ramp);
            if (m_tick > ramp + s_roll)
            begin
                latch_phase(PH_ROLL);
                m_phase = PH_FOLD;
                m_left  = ~m_left;
                m_tick  = 0;
            end
            else
                bump();
            return 1;
        end
        ramp = (r_fold == 0) ? 1 : r_fold;
        r = interpolate(PH_FOLD, ramp);
        if (m_tick >= ramp + s_fold)
        begin
            latch_phase(PH_FOLD);
            m_phase = it.upside ? PH_ROLL : PH_STAND;
            m_tick  = 0;
        end
        else
            bump();
        return 1;
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output side: random stalls and checking
    always @(posedge clk)
    begin
        setpoint_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_setpoints.size() == 0)
            begin
                $display("%t unexpected result legs=%h phase=%0d", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = pending_setpoints.pop_front();
                if (want.legs !== m_tdata)
                begin
                    $display("%t setpoint mismatch exp=%h got=%h", $time, want.legs, m_tdata);
                    errors++;
                end
                if (want.ph !== m_tuser)
                begin
                    $display("%t phase mismatch exp=%0d got=%0d", $time, want.ph, m_tuser);
                    errors++;
                end
            end
        end
    end

    bit quiet_in, quiet_out;
    int stall_left;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (m_tready && m_tvalid)
        begin
            stall_left = quiet_out ? 0 : $urandom_range(0, 5);
            m_tready <= (stall_left == 0);
        end
        else if (!m_tready)
        begin
            if (stall_left > 0)
                stall_left--;
            if (stall_left == 0)
                m_tready <= 1'b1;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_STANDUP_RAMP: r_stand = val;
            CFG_FOLD_RAMP:    r_fold  = val;
            CFG_FOLD_SETTLE:  s_fold  = val;
            CFG_ROLL_RAMP:    r_roll  = val;
            CFG_ROLL_SETTLE:  s_roll  = val;
            CFG_STAND_MIN:    h_min   = val[11:0];
            CFG_STAND_MAX:    h_max   = val[11:0];
            CFG_LOW_HEIGHT:   h_low   = val[11:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // wait for the block to drain before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_setpoints.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic send_item(item_t it, bit known, setpoint_t res);
        setpoint_t r;
        bit        has;
        int        gap;
        gap = quiet_in ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {3'b000, it.legs, it.height, it.upside};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        has = predict_setpoints(it, r);
        if (has)
        begin
            if (known && (r !== res))
                $display("%t table row disagrees with prediction exp=%h got=%h",
                         $time, res, r);
            pending_setpoints.push_back(known ? res : r);
        end
    endtask

    function automatic logic [191:0] rand_legs();
        logic [191:0] v;
        for (int k = 0; k < 6; k++)
            v[k * 32 +: 32] = $urandom;
        return v;
    endfunction

    function automatic item_t mk(logic cmd, logic up, logic [11:0] h, logic [191:0] l);
        item_t it;
        it.cmd = cmd;
        it.upside = up;
        it.height = h;
        it.legs = l;
        return it;
    endfunction

    row_t         table_rows[$];
    setpoint_t    fold0;
    logic [191:0] ones_legs;

    initial
    begin
        item_t it;
        int    burst;
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_STANDUP_RAMP;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        quiet_in = 0;
        quiet_out = 0;
        r_stand = 500; r_fold = 400; s_fold = 100; r_roll = 100; s_roll = 150;
        h_min = 200; h_max = 450; h_low = 100;
        m_phase = PH_FOLD; m_tick = 0; m_left = 1'b1;
        for (int k = 0; k < 12; k++)
            m_start[k] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short ramps so the directed part crosses every phase
        cfg_write(CFG_FOLD_RAMP, 16'd0);
        cfg_write(CFG_FOLD_SETTLE, 16'd0);
        cfg_write(CFG_ROLL_RAMP, 16'd1);
        cfg_write(CFG_ROLL_SETTLE, 16'd0);
        cfg_write(CFG_STANDUP_RAMP, 16'd2);

        // enter with all-zero pose upside down: fold, first tick holds start
        ones_legs = '1;
        table_rows.push_back({mk(1'b0, 1'b1, 12'd0, '0), 1'b0, setpoint_t'('0)});
        fold0.legs = '0;
        fold0.ph = PH_FOLD;
        table_rows.push_back({mk(1'b1, 1'b1, 12'd4095, ones_legs), 1'b1, fold0});
        for (int k = 0; k < 6; k++)
            table_rows.push_back({mk(1'b1, 1'b1, 12'd0, rand_legs()), 1'b0, setpoint_t'('0)});
        // enter all ones, stand window edges
        table_rows.push_back({mk(1'b0, 1'b0, 12'd200, ones_legs), 1'b0, setpoint_t'('0)});
        table_rows.push_back({mk(1'b0, 1'b0, 12'd450, ones_legs), 1'b0, setpoint_t'('0)});
        table_rows.push_back({mk(1'b0, 1'b0, 12'd201, ones_legs), 1'b0, setpoint_t'('0)});
        // stand ramp, then abort on low height late in the ramp
        table_rows.push_back({mk(1'b1, 1'b0, 12'd300, '0), 1'b0, setpoint_t'('0)});
        table_rows.push_back({mk(1'b1, 1'b0, 12'd300, '0), 1'b0, setpoint_t'('0)});
        table_rows.push_back({mk(1'b1, 1'b0, 12'd0, rand_legs()), 1'b0, setpoint_t'('0)});
        table_rows.push_back({mk(1'b1, 1'b0, 12'd0, '0), 1'b0, setpoint_t'('0)});
        // fold to stand, then upside-down abort
        table_rows.push_back({mk(1'b1, 1'b0, 12'd300, '0), 1'b0, setpoint_t'('0)});
        table_rows.push_back({mk(1'b1, 1'b0, 12'd300, '0), 1'b0, setpoint_t'('0)});
        table_rows.push_back({mk(1'b1, 1'b0, 12'd300, '0), 1'b0, setpoint_t'('0)});
        table_rows.push_back({mk(1'b1, 1'b0, 12'd300, '0), 1'b0, setpoint_t'('0)});
        table_rows.push_back({mk(1'b1, 1'b1, 12'd300, rand_legs()), 1'b0, setpoint_t'('0)});
        for (int k = 0; k < 4; k++)
            table_rows.push_back({mk(1'b1, 1'b1, 12'd300, '0), 1'b0, setpoint_t'('0)});

        foreach (table_rows[i])
            send_item(table_rows[i].it, table_rows[i].known, table_rows[i].res);
        settle();

        // random part: several register settings, extremes among them
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin
                    cfg_write(CFG_STANDUP_RAMP, 16'hFFFF);
                    cfg_write(CFG_FOLD_RAMP, 16'd1);
                    cfg_write(CFG_FOLD_SETTLE, 16'hFFFF);
                    cfg_write(CFG_STAND_MIN, 16'd0);
                    cfg_write(CFG_STAND_MAX, 16'hFFFF);
                    cfg_write(CFG_LOW_HEIGHT, 16'd4095);
                end
                1: begin
                    cfg_write(CFG_FOLD_SETTLE, 16'd0);
                    cfg_write(CFG_ROLL_RAMP, 16'hFFFF);
                    cfg_write(CFG_ROLL_SETTLE, 16'hFFFF);
                    cfg_write(CFG_STAND_MAX, 16'd0);
                end
                default: begin
                    cfg_write(CFG_STANDUP_RAMP, 16'($urandom_range(0, 12)));
                    cfg_write(CFG_FOLD_RAMP, 16'($urandom_range(0, 8)));
                    cfg_write(CFG_FOLD_SETTLE, 16'($urandom_range(0, 5)));
                    cfg_write(CFG_ROLL_RAMP, 16'($urandom_range(0, 8)));
                    cfg_write(CFG_ROLL_SETTLE, 16'($urandom_range(0, 5)));
                    cfg_write(CFG_STAND_MIN, 16'($urandom_range(0, 300)));
                    cfg_write(CFG_STAND_MAX, 16'($urandom_range(200, 4095)));
                    cfg_write(CFG_LOW_HEIGHT, 16'($urandom_range(0, 4095)));
                end
            endcase
            quiet_in  = (p == 3);
            quiet_out = (p == 3);
            for (int n = 0; n < 90; n++)
            begin
                // mostly ticks, an occasional re-enter
                burst = $urandom_range(0, 15);
                it = mk(burst == 0, $urandom_range(0, 3) == 0,
                        12'($urandom), rand_legs());
                if (burst == 0)
                    it.cmd = 1'b0;
                else
                    it.cmd = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    it.height = 12'($urandom_range(0, 500));
                send_item(it, 1'b0, setpoint_t'('0));
            end
            settle();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
